[sv/chbf_pkg.sv]
// Shared types and constants for the brute-force convex hull block.
// No dependencies; imported by convex_hull_brute_force.
package chbf_pkg;

	// Stream field widths; these are fixed by the bus format.
	localparam int FIELD_W = 16;
	localparam int TDATA_W = 32;

	// Sign of a cross product
	typedef enum logic [1:0] {
		SGN_ZERO = 2'd0,
		SGN_POS  = 2'd1,
		SGN_NEG  = 2'd2
	} sgn_t;

endpackage

[sv/chbf_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module chbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/convex_hull_brute_force.sv]
// Brute-force convex hull: point store, pruning sequencer, hull emission.
// Depends on chbf_pkg and chbf_ram.
//
// channel   | dir | fields (low bit first)                  | framing
// s_axis    | in  | tdata: point_x[15:0], point_y[31:16]    | tlast = last_point
// m_axis    | out | tdata: hull_x[15:0], hull_y[31:16]      | tlast = hull_last
//
// Points load one per cycle. After the last point the set is pruned by a sequencer
// around the single point memory read port: each (a,b,c) triple and each live d
// pass through address, diff, product and compare states, as does each point in the
// chain split; then one store scan per emitted chain vertex orders the output,
// and output stalls add to the time.
// Asynchronous reset clears the point count and all live flags.
// Input is not taken while a set is being processed or emitted; output stalls hold.
module convex_hull_brute_force
	import chbf_pkg::*;
#(
	parameter int MAX_POINTS = 16,
	parameter int COORD_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,   // point_x, point_y
	input  logic               s_axis_tlast,   // last_point
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,   // hull_x, hull_y
	output logic               m_axis_tlast    // hull_last
);

	localparam int IW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int CB  = COORD_BITS;
	localparam int PW  = 2 * CB;
	localparam int PRW = 2 * CB + 2;

	typedef enum logic [4:0] {
		ST_LOAD, ST_DUP_A, ST_DUP_AW, ST_DUP_B, ST_DUP_BW,
		ST_PA, ST_PA_W, ST_PB, ST_PB_W,
		ST_PC, ST_PC_W, ST_PC_M, ST_PC_R,
		ST_PD, ST_PD_W, ST_PD_M, ST_PD_R,
		ST_EX, ST_EX_W, ST_PT, ST_PT_W, ST_PT_M, ST_PT_R,
		ST_NEXT, ST_SC, ST_SC_W, ST_OUT
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q, ia_q, ib_q, ic_q, id_q;
	logic [MAX_POINTS-1:0] alive_q, lower_q;
	logic [CB-1:0]         a_x_q, a_y_q, b_x_q, b_y_q, c_x_q, c_y_q;
	logic [CB-1:0]         lo_x_q, lo_y_q, hi_x_q, hi_y_q, best_x_q, best_y_q;
	logic [CB-1:0]         prev_x_q, prev_y_q, out_x_q, out_y_q;
	logic [IW-1:0]         lo_idx_q, hi_idx_q;
	logic                  found_q, best_found_q, lo_done_q, hi_done_q, scan_lower_q;
	logic [CW-1:0]         nl_q, nu_q, rem_q;
	sgn_t                  sg1_q, sg2_q, sg3_q;

	// point memory
	logic          ram_we;
	logic [IW-1:0] ram_raddr;
	logic [PW-1:0] ram_rdata;
	logic [CB-1:0] r_x, r_y, in_x, in_y;

	assign in_x = CB'(s_axis_tdata[FIELD_W-1:0]);
	assign in_y = CB'(s_axis_tdata[TDATA_W-1:FIELD_W]);
	assign r_x  = ram_rdata[CB-1:0];
	assign r_y  = ram_rdata[PW-1:CB];
	assign ram_we = (state_q == ST_LOAD) && s_axis_tvalid && (count_q < CW'(MAX_POINTS));

	chbf_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pts (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IW-1:0]),
		.wdata({in_y, in_x}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// read address follows the loop that owns the port
	always_comb begin
		case (state_q)
			ST_DUP_A, ST_PA:                 ram_raddr = ia_q[IW-1:0];
			ST_DUP_B, ST_PB:                 ram_raddr = ib_q[IW-1:0];
			ST_PC:                           ram_raddr = ic_q[IW-1:0];
			ST_PD, ST_EX, ST_PT, ST_SC:      ram_raddr = id_q[IW-1:0];
			default:                         ram_raddr = '0;
		endcase
	end

	function automatic logic lex_lt(input logic [CB-1:0] ix, iy, jx, jy);
		return (ix < jx) || ((ix == jx) && (iy < jy));
	endfunction

	// three orientation lanes: diffs, then products, then compare
	logic [CB-1:0]         ox [3], oy [3], px [3], py [3], qx [3], qy [3];
	logic signed [CB:0]    dpx_s1 [3], dpy_s1 [3], dqx_s1 [3], dqy_s1 [3];
	logic signed [PRW-1:0] ml_s2 [3], mr_s2 [3];
	sgn_t                  sgn [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ox[k] = '0; oy[k] = '0; px[k] = '0; py[k] = '0; qx[k] = '0; qy[k] = '0;
		end
		case (state_q)
			ST_PC_W: begin
				ox[0] = a_x_q; oy[0] = a_y_q; px[0] = b_x_q; py[0] = b_y_q; qx[0] = r_x;   qy[0] = r_y;
				ox[1] = a_x_q; oy[1] = a_y_q; px[1] = r_x;   py[1] = r_y;   qx[1] = b_x_q; qy[1] = b_y_q;
				ox[2] = b_x_q; oy[2] = b_y_q; px[2] = r_x;   py[2] = r_y;   qx[2] = a_x_q; qy[2] = a_y_q;
			end
			ST_PD_W: begin
				ox[0] = a_x_q; oy[0] = a_y_q; px[0] = b_x_q; py[0] = b_y_q; qx[0] = r_x; qy[0] = r_y;
				ox[1] = a_x_q; oy[1] = a_y_q; px[1] = c_x_q; py[1] = c_y_q; qx[1] = r_x; qy[1] = r_y;
				ox[2] = b_x_q; oy[2] = b_y_q; px[2] = c_x_q; py[2] = c_y_q; qx[2] = r_x; qy[2] = r_y;
			end
			ST_PT_W: begin
				ox[0] = lo_x_q; oy[0] = lo_y_q; px[0] = hi_x_q; py[0] = hi_y_q;
				qx[0] = r_x;    qy[0] = r_y;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			dpx_s1[k] <= $signed({1'b0, px[k]}) - $signed({1'b0, ox[k]});
			dpy_s1[k] <= $signed({1'b0, py[k]}) - $signed({1'b0, oy[k]});
			dqx_s1[k] <= $signed({1'b0, qx[k]}) - $signed({1'b0, ox[k]});
			dqy_s1[k] <= $signed({1'b0, qy[k]}) - $signed({1'b0, oy[k]});
			ml_s2[k]  <= PRW'(dpx_s1[k]) * PRW'(dqy_s1[k]);
			mr_s2[k]  <= PRW'(dpy_s1[k]) * PRW'(dqx_s1[k]);
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (ml_s2[k] > mr_s2[k]) begin
				sgn[k] = SGN_POS;
			end else if (ml_s2[k] < mr_s2[k]) begin
				sgn[k] = SGN_NEG;
			end else begin
				sgn[k] = SGN_ZERO;
			end
		end
	end

	// loop-skip and selection helpers
	logic pc_skip, pd_skip, pt_skip, sc_member, sc_better, in_tri;
	logic a_lt_b, hi_lt_c, lo_lt_c;
	logic [CW-1:0] klo, khi;

	assign pc_skip = (ic_q == ia_q) || (ic_q == ib_q) || !alive_q[ia_q[IW-1:0]]
		|| !alive_q[ib_q[IW-1:0]] || !alive_q[ic_q[IW-1:0]];
	assign pd_skip = (id_q == ia_q) || (id_q == ib_q) || (id_q == ic_q)
		|| !alive_q[id_q[IW-1:0]];
	assign pt_skip = !alive_q[id_q[IW-1:0]] || (id_q[IW-1:0] == lo_idx_q)
		|| (id_q[IW-1:0] == hi_idx_q);
	assign sc_member = !pt_skip && (lower_q[id_q[IW-1:0]] == scan_lower_q);
	assign sc_better = scan_lower_q
		? (lex_lt(prev_x_q, prev_y_q, r_x, r_y)
			&& (!best_found_q || lex_lt(r_x, r_y, best_x_q, best_y_q)))
		: (lex_lt(r_x, r_y, prev_x_q, prev_y_q)
			&& (!best_found_q || lex_lt(best_x_q, best_y_q, r_x, r_y)));
	assign in_tri = (sg1_q == SGN_ZERO || sgn[0] == SGN_ZERO || sg1_q == sgn[0])
		&& (sg2_q == SGN_ZERO || sgn[1] == SGN_ZERO || sg2_q == sgn[1])
		&& (sg3_q == SGN_ZERO || sgn[2] == SGN_ZERO || sg3_q == sgn[2]);

	// collinear triple: order a, b then place c
	assign a_lt_b  = lex_lt(a_x_q, a_y_q, b_x_q, b_y_q);
	assign klo     = a_lt_b ? ia_q : ib_q;
	assign khi     = a_lt_b ? ib_q : ia_q;
	assign hi_lt_c = a_lt_b ? lex_lt(b_x_q, b_y_q, c_x_q, c_y_q)
	                        : lex_lt(a_x_q, a_y_q, c_x_q, c_y_q);
	assign lo_lt_c = a_lt_b ? lex_lt(a_x_q, a_y_q, c_x_q, c_y_q)
	                        : lex_lt(b_x_q, b_y_q, c_x_q, c_y_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0; ia_q <= '0; ib_q <= '0; ic_q <= '0; id_q <= '0;
			alive_q <= '0; lower_q <= '0;
			a_x_q <= '0; a_y_q <= '0; b_x_q <= '0; b_y_q <= '0; c_x_q <= '0; c_y_q <= '0;
			lo_x_q <= '0; lo_y_q <= '0; hi_x_q <= '0; hi_y_q <= '0;
			best_x_q <= '0; best_y_q <= '0; prev_x_q <= '0; prev_y_q <= '0;
			out_x_q <= '0; out_y_q <= '0; lo_idx_q <= '0; hi_idx_q <= '0;
			found_q <= 1'b0; best_found_q <= 1'b0; lo_done_q <= 1'b0; hi_done_q <= 1'b0;
			scan_lower_q <= 1'b0; nl_q <= '0; nu_q <= '0; rem_q <= '0;
			sg1_q <= SGN_ZERO; sg2_q <= SGN_ZERO; sg3_q <= SGN_ZERO;
		end else begin
			case (state_q)
				// store points until the last request
				ST_LOAD: begin
					if (s_axis_tvalid) begin
						if (ram_we) begin
							alive_q[count_q[IW-1:0]] <= 1'b1;
							count_q <= count_q + 1'b1;
						end
						if (s_axis_tlast) begin
							ia_q    <= '0;
							state_q <= ST_DUP_A;
						end
					end
				end
				// drop later copies of a coordinate pair
				ST_DUP_A: begin
					if (ia_q == count_q) begin
						ia_q    <= '0;
						state_q <= ST_PA;
					end else if (!alive_q[ia_q[IW-1:0]]) begin
						ia_q <= ia_q + 1'b1;
					end else begin
						state_q <= ST_DUP_AW;
					end
				end
				ST_DUP_AW: begin
					a_x_q   <= r_x;
					a_y_q   <= r_y;
					ib_q    <= ia_q + 1'b1;
					state_q <= ST_DUP_B;
				end
				ST_DUP_B: begin
					if (ib_q == count_q) begin
						ia_q    <= ia_q + 1'b1;
						state_q <= ST_DUP_A;
					end else if (!alive_q[ib_q[IW-1:0]]) begin
						ib_q <= ib_q + 1'b1;
					end else begin
						state_q <= ST_DUP_BW;
					end
				end
				ST_DUP_BW: begin
					if (r_x == a_x_q && r_y == a_y_q) begin
						alive_q[ib_q[IW-1:0]] <= 1'b0;
					end
					ib_q    <= ib_q + 1'b1;
					state_q <= ST_DUP_B;
				end
				// outer loop over a
				ST_PA: begin
					if (ia_q == count_q) begin
						id_q    <= '0;
						found_q <= 1'b0;
						state_q <= ST_EX;
					end else begin
						state_q <= ST_PA_W;
					end
				end
				ST_PA_W: begin
					a_x_q   <= r_x;
					a_y_q   <= r_y;
					ib_q    <= '0;
					state_q <= ST_PB;
				end
				ST_PB: begin
					if (ib_q == count_q) begin
						ia_q    <= ia_q + 1'b1;
						state_q <= ST_PA;
					end else if (ib_q == ia_q) begin
						ib_q <= ib_q + 1'b1;
					end else begin
						state_q <= ST_PB_W;
					end
				end
				ST_PB_W: begin
					b_x_q   <= r_x;
					b_y_q   <= r_y;
					ic_q    <= '0;
					state_q <= ST_PC;
				end
				ST_PC: begin
					if (ic_q == count_q) begin
						ib_q    <= ib_q + 1'b1;
						state_q <= ST_PB;
					end else if (pc_skip) begin
						ic_q <= ic_q + 1'b1;
					end else begin
						state_q <= ST_PC_W;
					end
				end
				ST_PC_W: begin
					c_x_q   <= r_x;
					c_y_q   <= r_y;
					state_q <= ST_PC_M;
				end
				ST_PC_M: state_q <= ST_PC_R;
				// triangle orientation known; collinear triples lose their middle point
				ST_PC_R: begin
					if (sgn[0] == SGN_ZERO) begin
						if (hi_lt_c) begin
							alive_q[khi[IW-1:0]] <= 1'b0;
						end else if (lo_lt_c) begin
							alive_q[ic_q[IW-1:0]] <= 1'b0;
						end else begin
							alive_q[klo[IW-1:0]] <= 1'b0;
						end
						ic_q    <= ic_q + 1'b1;
						state_q <= ST_PC;
					end else begin
						sg1_q   <= sgn[0];
						sg2_q   <= sgn[1];
						sg3_q   <= sgn[2];
						id_q    <= '0;
						state_q <= ST_PD;
					end
				end
				ST_PD: begin
					if (id_q == count_q) begin
						ic_q    <= ic_q + 1'b1;
						state_q <= ST_PC;
					end else if (pd_skip) begin
						id_q <= id_q + 1'b1;
					end else begin
						state_q <= ST_PD_W;
					end
				end
				ST_PD_W: state_q <= ST_PD_M;
				ST_PD_M: state_q <= ST_PD_R;
				// points in or on the triangle are dropped
				ST_PD_R: begin
					if (in_tri) begin
						alive_q[id_q[IW-1:0]] <= 1'b0;
					end
					id_q    <= id_q + 1'b1;
					state_q <= ST_PD;
				end
				// find leftmost and rightmost survivors
				ST_EX: begin
					if (id_q == count_q) begin
						lo_done_q <= 1'b0;
						hi_done_q <= 1'b0;
						if (!found_q) begin
							alive_q <= '0;
							count_q <= '0;
							state_q <= ST_LOAD;
						end else if (lo_idx_q == hi_idx_q) begin
							rem_q   <= CW'(1);
							nl_q    <= '0;
							state_q <= ST_NEXT;
						end else begin
							id_q    <= '0;
							lower_q <= '0;
							nl_q    <= '0;
							nu_q    <= '0;
							state_q <= ST_PT;
						end
					end else if (!alive_q[id_q[IW-1:0]]) begin
						id_q <= id_q + 1'b1;
					end else begin
						state_q <= ST_EX_W;
					end
				end
				ST_EX_W: begin
					if (!found_q || lex_lt(r_x, r_y, lo_x_q, lo_y_q)) begin
						lo_x_q   <= r_x;
						lo_y_q   <= r_y;
						lo_idx_q <= id_q[IW-1:0];
					end
					if (!found_q || lex_lt(hi_x_q, hi_y_q, r_x, r_y)) begin
						hi_x_q   <= r_x;
						hi_y_q   <= r_y;
						hi_idx_q <= id_q[IW-1:0];
					end
					found_q <= 1'b1;
					id_q    <= id_q + 1'b1;
					state_q <= ST_EX;
				end
				// split survivors into lower and upper chains
				ST_PT: begin
					if (id_q == count_q) begin
						rem_q   <= nl_q + nu_q + CW'(2);
						state_q <= ST_NEXT;
					end else if (pt_skip) begin
						id_q <= id_q + 1'b1;
					end else begin
						state_q <= ST_PT_W;
					end
				end
				ST_PT_W: state_q <= ST_PT_M;
				ST_PT_M: state_q <= ST_PT_R;
				ST_PT_R: begin
					if (sgn[0] == SGN_NEG) begin
						lower_q[id_q[IW-1:0]] <= 1'b1;
						nl_q <= nl_q + 1'b1;
					end else begin
						nu_q <= nu_q + 1'b1;
					end
					id_q    <= id_q + 1'b1;
					state_q <= ST_PT;
				end
				// choose the next vertex to emit
				ST_NEXT: begin
					if (!lo_done_q) begin
						out_x_q   <= lo_x_q;
						out_y_q   <= lo_y_q;
						lo_done_q <= 1'b1;
						state_q   <= ST_OUT;
					end else if (nl_q != '0) begin
						scan_lower_q <= 1'b1;
						best_found_q <= 1'b0;
						id_q         <= '0;
						state_q      <= ST_SC;
					end else if (!hi_done_q) begin
						out_x_q   <= hi_x_q;
						out_y_q   <= hi_y_q;
						hi_done_q <= 1'b1;
						state_q   <= ST_OUT;
					end else begin
						scan_lower_q <= 1'b0;
						best_found_q <= 1'b0;
						id_q         <= '0;
						state_q      <= ST_SC;
					end
				end
				// nearest chain point beyond the previous vertex
				ST_SC: begin
					if (id_q == count_q) begin
						out_x_q <= best_x_q;
						out_y_q <= best_y_q;
						if (scan_lower_q) begin
							nl_q <= nl_q - 1'b1;
						end
						state_q <= ST_OUT;
					end else if (!sc_member) begin
						id_q <= id_q + 1'b1;
					end else begin
						state_q <= ST_SC_W;
					end
				end
				ST_SC_W: begin
					if (sc_better) begin
						best_x_q     <= r_x;
						best_y_q     <= r_y;
						best_found_q <= 1'b1;
					end
					id_q    <= id_q + 1'b1;
					state_q <= ST_SC;
				end
				// hold the vertex until the downstream takes it
				ST_OUT: begin
					if (m_axis_tready) begin
						prev_x_q <= out_x_q;
						prev_y_q <= out_y_q;
						rem_q    <= rem_q - 1'b1;
						if (rem_q == CW'(1)) begin
							alive_q <= '0;
							count_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_NEXT;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_LOAD);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {FIELD_W'(out_y_q), FIELD_W'(out_x_q)};
	assign m_axis_tlast  = (rem_q == CW'(1));

	// no live flag above the fill level while loading
	a_alive_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> (alive_q >> count_q) == '0)
		else $error("live flag set beyond stored count");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count overflow");

	// the final vertex empties the store
	a_final_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> count_q == '0 && alive_q == '0)
		else $error("store not emptied after final vertex");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> rem_q != '0)
		else $error("vertex emitted with no count left");

	// lower-chain bookkeeping never exceeds the stored points
	a_chain_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NEXT |-> nl_q <= count_q)
		else $error("lower chain count exceeds stored points");

endmodule

[tb/convex_hull_brute_force_tb.sv]
// Testbench for convex_hull_brute_force: drives point sets on s_axis, predicts the hull
// in a scoreboard class and checks every vertex seen on m_axis. Depends on chbf_pkg.
module convex_hull_brute_force_tb;
	import chbf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = 16;
	localparam int WDOG_LIMIT = 2000000;

	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
		logic        last;
	} vertex_t;

	// Hull predictor: holds the point store and the queue of expected vertices
	class hull_board;
		logic [15:0] px[NPTS];
		logic [15:0] py[NPTS];
		bit          alive[NPTS];
		int          count;
		vertex_t     pending[$];
		int          errors;

		function new();
			count = 0;
			errors = 0;
			foreach (alive[i]) alive[i] = 0;
		endfunction

		function sgn_t turn(int o, int a, int b);
			longint ax, ay, bx, by, l, r;
			ax = longint'(px[a]) - longint'(px[o]);
			ay = longint'(py[a]) - longint'(py[o]);
			bx = longint'(px[b]) - longint'(px[o]);
			by = longint'(py[b]) - longint'(py[o]);
			l = ax * by;
			r = ay * bx;
			return (l > r) ? SGN_POS : ((l < r) ? SGN_NEG : SGN_ZERO);
		endfunction

		function int sval(sgn_t s);
			return (s == SGN_POS) ? 1 : ((s == SGN_NEG) ? -1 : 0);
		endfunction

		function bit before_lex(int i, int j);
			return px[i] < px[j] || (px[i] == px[j] && py[i] < py[j]);
		endfunction

		function void sort_pts(ref int v[$]);
			int t, j;
			for (int i = 1; i < v.size(); i++) begin
				t = v[i];
				j = i;
				while (j > 0 && before_lex(t, v[j-1])) begin
					v[j] = v[j-1];
					j--;
				end
				v[j] = t;
			end
		endfunction

		function void drop_interior(int n);
			int s1, s2, s3, lo, hi;
			for (int a = 0; a < n; a++)
				for (int b = a + 1; b < n; b++)
					if (alive[a] && alive[b] && px[a] == px[b] && py[a] == py[b])
						alive[b] = 0;
			for (int a = 0; a < n; a++)
				for (int b = 0; b < n; b++) begin
					if (b == a) continue;
					for (int c = 0; c < n; c++) begin
						if (c == a || c == b) continue;
						if (!alive[a] || !alive[b] || !alive[c]) continue;
						s1 = sval(turn(a, b, c));
						if (s1 == 0) begin
							lo = a; hi = b;
							if (before_lex(hi, lo)) begin lo = b; hi = a; end
							if (before_lex(hi, c)) alive[hi] = 0;
							else if (before_lex(lo, c)) alive[c] = 0;
							else alive[lo] = 0;
							continue;
						end
						s2 = sval(turn(a, c, b));
						s3 = sval(turn(b, c, a));
						for (int d = 0; d < n; d++) begin
							if (d == a || d == b || d == c || !alive[d]) continue;
							if (s1 * sval(turn(a, b, d)) >= 0 &&
							    s2 * sval(turn(a, c, d)) >= 0 &&
							    s3 * sval(turn(b, c, d)) >= 0)
								alive[d] = 0;
						end
					end
				end
		endfunction

		// Note one accepted request; on a last point, queue the hull vertices
		function void note_point(logic [15:0] x, logic [15:0] y, logic last);
			int lower[$], upper[$], order[$];
			int lo, hi, n;
			bit found;
			vertex_t v;
			if (count < NPTS) begin
				px[count] = x;
				py[count] = y;
				alive[count] = 1;
				count++;
			end
			if (!last) return;
			n = count;
			drop_interior(n);
			found = 0; lo = 0; hi = 0;
			for (int i = 0; i < n; i++) begin
				if (!alive[i]) continue;
				if (!found) begin lo = i; hi = i; found = 1; continue; end
				if (before_lex(i, lo)) lo = i;
				if (before_lex(hi, i)) hi = i;
			end
			if (found) begin
				order.push_back(lo);
				if (hi != lo) begin
					for (int i = 0; i < n; i++) begin
						if (!alive[i] || i == lo || i == hi) continue;
						if (turn(lo, hi, i) == SGN_NEG) lower.push_back(i);
						else upper.push_back(i);
					end
					sort_pts(lower);
					sort_pts(upper);
					foreach (lower[i]) order.push_back(lower[i]);
					order.push_back(hi);
					for (int i = upper.size(); i > 0; i--) order.push_back(upper[i-1]);
				end
			end
			foreach (order[i]) begin
				v.x = px[order[i]];
				v.y = py[order[i]];
				v.last = (i == order.size() - 1);
				pending.push_back(v);
			end
			foreach (alive[i]) alive[i] = 0;
			count = 0;
		endfunction

		function void check_vertex(logic [15:0] x, logic [15:0] y, logic last);
			vertex_t e;
			if (pending.size() == 0) begin
				$error("unexpected vertex x=%0d y=%0d last=%0b", x, y, last);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (x !== e.x) begin
				$error("hull_x expected %0d got %0d", e.x, x);
				errors++;
			end
			if (y !== e.y) begin
				$error("hull_y expected %0d got %0d", e.y, y);
				errors++;
			end
			if (last !== e.last) begin
				$error("hull_last expected %0b got %0b", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // point_x[15:0], point_y[31:16]
	logic        s_axis_tlast = 0;    // last_point
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;        // hull_x[15:0], hull_y[31:16]
	logic        m_axis_tlast;        // hull_last

	hull_board sb = new();
	int idle_cycles = 0;
	bit stim_done = 0;

	convex_hull_brute_force u_top (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Send one point request, with a random gap before it; valid stays up after acceptance
	task automatic send_point(logic [15:0] x, logic [15:0] y, logic last);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {y, x};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_point(x, y, last);
	endtask

	// Random set of n points in a box of random extent
	task automatic send_set(int n);
		logic [15:0] span;
		logic [15:0] bx, by;
		case ($urandom_range(0, 3))
			0: span = 16'd7;
			1: span = 16'd255;
			default: span = 16'hFFFF;
		endcase
		for (int i = 0; i < n; i++) begin
			bx = 16'($urandom_range(0, span));
			by = 16'($urandom_range(0, span));
			if ($urandom_range(0, 7) == 0) begin
				bx = 16'hFFFF - bx;
				by = 16'hFFFF - by;
			end
			send_point(bx, by, i == n - 1);
		end
	endtask

	// Output side: random stall per vertex
	initial begin
		int stall;
		forever begin
			stall = $urandom_range(0, 6);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall > 0) begin
				m_axis_tready <= 0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_vertex(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast);
		end
	end

	// Watchdog on cycles with no accepted request or vertex
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || stim_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int sent, wait_cnt;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: single point, duplicate, two points, extremes, collinear, square
		send_point(16'd5, 16'd9, 1);
		send_point(16'd3, 16'd3, 0);
		send_point(16'd3, 16'd3, 1);
		send_point(16'hFFFF, 16'h0000, 0);
		send_point(16'h0000, 16'hFFFF, 1);
		send_point(16'd0, 16'd0, 0);
		send_point(16'd2, 16'd2, 0);
		send_point(16'd1, 16'd1, 1);
		send_point(16'd0, 16'd0, 0);
		send_point(16'hFFFF, 16'd0, 0);
		send_point(16'hFFFF, 16'hFFFF, 0);
		send_point(16'd0, 16'hFFFF, 0);
		send_point(16'h8000, 16'h8000, 0);
		send_point(16'hAAAA, 16'h5555, 1);
		// Overfull set: 18 points, last mark on an ignored one
		for (int i = 0; i < 18; i++)
			send_point(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				i == 17);

		// Random sets, mostly small
		sent = 0;
		while (sent < 108) begin
			int n;
			n = ($urandom_range(0, 9) == 0) ? NPTS : $urandom_range(1, 8);
			send_set(n);
			sent += n;
		end
		s_axis_tvalid <= 0;

		wait_cnt = 0;
		while (sb.pending.size() != 0 && wait_cnt < WDOG_LIMIT) begin
			@(posedge clk);
			wait_cnt++;
		end
		stim_done = 1;
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[filelist.f]
sv/chbf_pkg.sv
sv/chbf_ram.sv
sv/convex_hull_brute_force.sv
tb/convex_hull_brute_force_tb.sv
